>>> rtl/dta_pkg.sv
package dta_pkg;

    // table geometry
    localparam int DEPTH      = 256;
    localparam int DATA_WIDTH = 32;
    localparam int ADDR_W     = $clog2(DEPTH);

    // priority encoder tree: groups of GRP flags, then a pick over the groups
    localparam int GRP    = 16;
    localparam int GRP_W  = $clog2(GRP);
    localparam int NGRP   = DEPTH / GRP;
    localparam int NGRP_W = $clog2(NGRP);

    // actions
    localparam logic [2:0] ACT_ALLOC    = 3'd0;
    localparam logic [2:0] ACT_SET      = 3'd1;
    localparam logic [2:0] ACT_FREE     = 3'd2;
    localparam logic [2:0] ACT_LOOKUP   = 3'd3;
    localparam logic [2:0] ACT_REASSIGN = 3'd4;
    localparam logic [2:0] ACT_FIND     = 3'd5;

    // result status codes
    localparam logic [1:0] STS_OK      = 2'd0;
    localparam logic [1:0] STS_INVALID = 2'd1;
    localparam logic [1:0] STS_IN_USE  = 2'd2;
    localparam logic [1:0] STS_FULL    = 2'd3;

    // commands to the entry state flags
    typedef struct packed {
        logic              snap;
        logic              occ;
        logic [ADDR_W-1:0] occ_idx;
        logic              rel;
        logic [ADDR_W-1:0] rel_idx;
    } t_st_cmd;

    // allocation candidates from the encoder tree
    typedef struct packed {
        logic              fresh_ok;
        logic [ADDR_W-1:0] fresh_idx;
        logic              closed_ok;
        logic [ADDR_W-1:0] closed_idx;
    } t_pick;

    // write port of the data and tag store
    typedef struct packed {
        logic                  we;
        logic [ADDR_W-1:0]     addr;
        logic [DATA_WIDTH-1:0] data;
        logic [7:0]            tag;
    } t_wr;

    // one result item
    typedef struct packed {
        logic [1:0]  status;
        logic [7:0]  index;
        logic [31:0] data;
        logic [7:0]  tag;
    } t_res;

endpackage

>>> rtl/dta_status.sv
module dta_status (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  dta_pkg::t_st_cmd            i_cmd,
    output logic [dta_pkg::DEPTH-1:0]   o_used,
    output dta_pkg::t_pick              o_pick
);

    logic [dta_pkg::DEPTH-1:0]  r_used;
    logic [dta_pkg::DEPTH-1:0]  r_closed;
    logic [dta_pkg::ADDR_W:0]   r_count;
    logic [dta_pkg::ADDR_W-1:0] r_last;
    logic [dta_pkg::DEPTH-1:0]  n_used;
    logic [dta_pkg::DEPTH-1:0]  n_closed;
    logic [dta_pkg::ADDR_W:0]   n_count;
    logic [dta_pkg::ADDR_W-1:0] n_last;

    logic [dta_pkg::DEPTH-1:0]  w_fresh;
    logic [dta_pkg::DEPTH-1:0]  w_hi;

    // first tree stage: per group any flag and lowest position
    logic [dta_pkg::NGRP-1:0]  r_f_any;
    logic [dta_pkg::NGRP-1:0]  r_h_any;
    logic [dta_pkg::NGRP-1:0]  r_a_any;
    logic [dta_pkg::GRP_W-1:0] r_f_pos [dta_pkg::NGRP];
    logic [dta_pkg::GRP_W-1:0] r_h_pos [dta_pkg::NGRP];
    logic [dta_pkg::GRP_W-1:0] r_a_pos [dta_pkg::NGRP];

    logic [dta_pkg::NGRP_W-1:0] w_f_grp;
    logic [dta_pkg::NGRP_W-1:0] w_h_grp;
    logic [dta_pkg::NGRP_W-1:0] w_a_grp;

    function automatic logic [dta_pkg::GRP_W-1:0] low_pos(input logic [dta_pkg::GRP-1:0] v);
        logic [dta_pkg::GRP_W-1:0] p;
        p = '0;
        for (int k = dta_pkg::GRP - 1; k >= 0; k--) begin
            if (v[k]) p = dta_pkg::GRP_W'(k);
        end
        return p;
    endfunction

    function automatic logic [dta_pkg::NGRP_W-1:0] low_grp(input logic [dta_pkg::NGRP-1:0] v);
        logic [dta_pkg::NGRP_W-1:0] p;
        p = '0;
        for (int k = dta_pkg::NGRP - 1; k >= 0; k--) begin
            if (v[k]) p = dta_pkg::NGRP_W'(k);
        end
        return p;
    endfunction

    // candidate vectors: fresh entries, closed entries after the last freed one, all closed
    always_comb begin
        w_fresh = ~r_used & ~r_closed;
        for (int i = 0; i < dta_pkg::DEPTH; i++) begin
            w_hi[i] = r_closed[i] && (dta_pkg::ADDR_W'(i) > r_last);
        end
    end

    // first tree stage, taken when an allocation starts
    always_ff @(posedge i_clk) begin
        if (i_cmd.snap) begin
            for (int g = 0; g < dta_pkg::NGRP; g++) begin
                r_f_any[g] <= |w_fresh[g*dta_pkg::GRP +: dta_pkg::GRP];
                r_h_any[g] <= |w_hi[g*dta_pkg::GRP +: dta_pkg::GRP];
                r_a_any[g] <= |r_closed[g*dta_pkg::GRP +: dta_pkg::GRP];
                r_f_pos[g] <= low_pos(w_fresh[g*dta_pkg::GRP +: dta_pkg::GRP]);
                r_h_pos[g] <= low_pos(w_hi[g*dta_pkg::GRP +: dta_pkg::GRP]);
                r_a_pos[g] <= low_pos(r_closed[g*dta_pkg::GRP +: dta_pkg::GRP]);
            end
        end
    end

    // second tree stage: lowest group, circular wrap for closed entries
    always_comb begin
        w_f_grp = low_grp(r_f_any);
        w_h_grp = low_grp(r_h_any);
        w_a_grp = low_grp(r_a_any);
        o_pick.fresh_ok  = |r_f_any;
        o_pick.fresh_idx = {w_f_grp, r_f_pos[w_f_grp]};
        o_pick.closed_ok = |r_a_any;
        if (|r_h_any) begin
            o_pick.closed_idx = {w_h_grp, r_h_pos[w_h_grp]};
        end else begin
            o_pick.closed_idx = {w_a_grp, r_a_pos[w_a_grp]};
        end
    end

    // occupy and release, table wipe when the last entry is freed
    always_comb begin
        n_used   = r_used;
        n_closed = r_closed;
        n_count  = r_count;
        n_last   = r_last;
        if (i_cmd.occ) begin
            n_used[i_cmd.occ_idx]   = 1'b1;
            n_closed[i_cmd.occ_idx] = 1'b0;
            n_count                 = r_count + 1'b1;
        end else if (i_cmd.rel) begin
            n_count = r_count - 1'b1;
            n_last  = i_cmd.rel_idx;
            if (r_count == (dta_pkg::ADDR_W+1)'(1)) begin
                n_used   = '0;
                n_closed = '0;
            end else begin
                n_used[i_cmd.rel_idx]   = 1'b0;
                n_closed[i_cmd.rel_idx] = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used   <= '0;
            r_closed <= '0;
            r_count  <= '0;
            r_last   <= dta_pkg::ADDR_W'(dta_pkg::DEPTH - 1);
        end else begin
            r_used   <= n_used;
            r_closed <= n_closed;
            r_count  <= n_count;
            r_last   <= n_last;
        end
    end

    assign o_used = r_used;

    // in-use count tracks the flags
    a_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(r_used) == int'(r_count))
        else $error("in-use count differs from in-use flags");

    // an entry is never in use and closed at once
    a_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_used & r_closed) == '0)
        else $error("entry both in use and closed");

    // freeing the last in-use entry leaves every entry fresh
    a_wipe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.rel && r_count == (dta_pkg::ADDR_W+1)'(1))
        |=> (r_used == '0 && r_closed == '0))
        else $error("table not wiped after last free");

endmodule

>>> rtl/dta_store.sv
module dta_store (
    input  logic                             i_clk,
    input  dta_pkg::t_wr                     i_wr,
    input  logic [dta_pkg::ADDR_W-1:0]       i_raddr,
    output logic [dta_pkg::DATA_WIDTH-1:0]   o_rdata,
    output logic [7:0]                       o_rtag
);

    logic [dta_pkg::DATA_WIDTH-1:0] r_data_mem [dta_pkg::DEPTH];
    logic [7:0]                     r_tag_mem  [dta_pkg::DEPTH];

    // single write port
    always_ff @(posedge i_clk) begin
        if (i_wr.we) begin
            r_data_mem[i_wr.addr] <= i_wr.data;
            r_tag_mem[i_wr.addr]  <= i_wr.tag;
        end
    end

    // registered read: data appears in the cycle after the address
    always_ff @(posedge i_clk) begin
        o_rdata <= r_data_mem[i_raddr];
        o_rtag  <= r_tag_mem[i_raddr];
    end

endmodule

>>> rtl/descriptor_table_allocator_core.sv
// channel | valid      | stall       | payload
// --------+------------+-------------+---------------------------------------------------
// in      | i_in_valid | o_in_stall  | i_action, i_index, i_data_value, i_type_value
// out     | o_out_valid| i_out_stall | o_status, o_result_index, o_result_data, o_result_type
//
// set, free, reassign and unknown actions: result from S_EXEC; no new item until back in S_IDLE
// lookup of a used entry: result from S_LOOK; allocate: from S_ALLOC, two-stage encoder
// find: walks the entries in S_FIND to a match or the last entry, one store read per entry
// a finished result waits while the output register is stalled; no transfer in until it moves
// synchronous active-low reset clears all flags at once; no clearing pass
module descriptor_table_allocator_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [2:0]  i_action,
    input  logic [7:0]  i_index,
    input  logic [31:0] i_data_value,
    input  logic [7:0]  i_type_value,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [1:0]  o_status,
    output logic [7:0]  o_result_index,
    output logic [31:0] o_result_data,
    output logic [7:0]  o_result_type
);

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_EXEC  = 6'b000010,
        S_ALLOC = 6'b000100,
        S_LOOK  = 6'b001000,
        S_FIND  = 6'b010000,
        S_HOLD  = 6'b100000
    } t_state;

    t_state r_state;
    t_state n_state;

    logic [2:0]               r_action;
    logic [7:0]               r_index;
    logic [31:0]              r_data;
    logic [7:0]               r_tag;
    logic [dta_pkg::ADDR_W:0] r_ptr;
    logic [dta_pkg::ADDR_W:0] n_ptr;
    logic                     r_chk_v;
    logic                     n_chk_v;
    logic [dta_pkg::ADDR_W-1:0] r_chk_addr;
    logic [dta_pkg::ADDR_W-1:0] n_chk_addr;
    dta_pkg::t_res            r_out;
    logic                     r_out_valid;
    dta_pkg::t_res            r_hold;

    dta_pkg::t_st_cmd         w_cmd;
    dta_pkg::t_pick           w_pick;
    dta_pkg::t_wr             w_wr;
    dta_pkg::t_res            w_res;
    logic                     w_fin;
    logic                     w_slot_free;
    logic [dta_pkg::DEPTH-1:0] w_used_vec;
    logic                     w_valid;
    logic                     w_used;
    logic [dta_pkg::ADDR_W-1:0] w_addr;
    logic [dta_pkg::ADDR_W-1:0] w_raddr;
    logic [dta_pkg::DATA_WIDTH-1:0] w_rdata;
    logic [7:0]               w_rtag;
    logic [dta_pkg::DATA_WIDTH-1:0] w_dval;

    dta_status u_status (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (w_cmd),
        .o_used  (w_used_vec),
        .o_pick  (w_pick)
    );

    dta_store u_store (
        .i_clk   (i_clk),
        .i_wr    (w_wr),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata),
        .o_rtag  (w_rtag)
    );

    // index checks on the held item
    assign w_valid     = 32'(r_index) < 32'(dta_pkg::DEPTH);
    assign w_addr      = dta_pkg::ADDR_W'(r_index);
    assign w_used      = w_valid && w_used_vec[w_addr];
    assign w_dval      = dta_pkg::DATA_WIDTH'(r_data);
    assign w_slot_free = !r_out_valid || !i_out_stall;

    // sequencer
    always_comb begin
        n_state    = r_state;
        n_ptr      = r_ptr;
        n_chk_v    = 1'b0;
        n_chk_addr = r_ptr[dta_pkg::ADDR_W-1:0];
        w_cmd      = '0;
        w_wr       = '0;
        w_wr.addr  = w_addr;
        w_wr.data  = w_dval;
        w_wr.tag   = r_tag;
        w_raddr    = (r_state == S_FIND) ? r_ptr[dta_pkg::ADDR_W-1:0] : w_addr;
        w_fin      = 1'b0;
        w_res      = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) n_state = S_EXEC;
            end
            S_EXEC: begin
                w_res.index  = r_index;
                w_res.status = dta_pkg::STS_INVALID;
                case (r_action)
                    dta_pkg::ACT_ALLOC: begin
                        w_cmd.snap = 1'b1;
                        n_state    = S_ALLOC;
                    end
                    dta_pkg::ACT_SET: begin
                        w_fin = 1'b1;
                        if (w_valid && w_used) begin
                            w_res.status = dta_pkg::STS_IN_USE;
                        end else if (w_valid) begin
                            w_res.status  = dta_pkg::STS_OK;
                            w_cmd.occ     = 1'b1;
                            w_cmd.occ_idx = w_addr;
                            w_wr.we       = 1'b1;
                        end
                    end
                    dta_pkg::ACT_FREE: begin
                        w_fin = 1'b1;
                        if (w_used) begin
                            w_res.status  = dta_pkg::STS_OK;
                            w_cmd.rel     = 1'b1;
                            w_cmd.rel_idx = w_addr;
                        end
                    end
                    dta_pkg::ACT_LOOKUP: begin
                        if (w_used) n_state = S_LOOK;
                        else w_fin = 1'b1;
                    end
                    dta_pkg::ACT_REASSIGN: begin
                        w_fin = 1'b1;
                        if (w_used) begin
                            w_res.status = dta_pkg::STS_OK;
                            w_wr.we      = 1'b1;
                        end
                    end
                    dta_pkg::ACT_FIND: begin
                        n_ptr   = '0;
                        n_state = S_FIND;
                    end
                    default: begin
                        w_fin       = 1'b1;
                        w_res.index = '0;
                    end
                endcase
            end
            S_ALLOC: begin
                w_fin = 1'b1;
                if (w_pick.fresh_ok || w_pick.closed_ok) begin
                    w_cmd.occ     = 1'b1;
                    w_cmd.occ_idx = w_pick.fresh_ok ? w_pick.fresh_idx : w_pick.closed_idx;
                    w_wr.we       = 1'b1;
                    w_wr.addr     = w_cmd.occ_idx;
                    w_res.status  = dta_pkg::STS_OK;
                    w_res.index   = 8'(w_cmd.occ_idx);
                end else begin
                    w_res.status = dta_pkg::STS_FULL;
                end
            end
            S_LOOK: begin
                w_fin        = 1'b1;
                w_res.status = dta_pkg::STS_OK;
                w_res.index  = r_index;
                w_res.data   = 32'(w_rdata);
                w_res.tag    = w_rtag;
            end
            S_FIND: begin
                // issue one read a cycle, compare the entry read the cycle before
                if (!r_ptr[dta_pkg::ADDR_W]) begin
                    n_chk_v = 1'b1;
                    n_ptr   = r_ptr + 1'b1;
                end
                if (r_chk_v && w_used_vec[r_chk_addr] && w_rdata == w_dval) begin
                    w_fin        = 1'b1;
                    w_res.status = dta_pkg::STS_OK;
                    w_res.index  = 8'(r_chk_addr);
                end else if (r_chk_v &&
                             r_chk_addr == dta_pkg::ADDR_W'(dta_pkg::DEPTH - 1)) begin
                    w_fin        = 1'b1;
                    w_res.status = dta_pkg::STS_FULL;
                end
            end
            S_HOLD: begin
                w_fin = 1'b1;
                w_res = r_hold;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        if (w_fin) begin
            n_state = w_slot_free ? S_IDLE : S_HOLD;
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_chk_v     <= 1'b0;
        end else begin
            r_state <= n_state;
            r_chk_v <= n_chk_v;
            if (w_fin && w_slot_free) r_out_valid <= 1'b1;
            else if (!i_out_stall) r_out_valid <= 1'b0;
        end
    end

    // item capture, walk pointer and result registers
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_in_valid) begin
            r_action <= i_action;
            r_index  <= i_index;
            r_data   <= i_data_value;
            r_tag    <= i_type_value;
        end
        r_ptr      <= n_ptr;
        r_chk_addr <= n_chk_addr;
        if (w_fin && w_slot_free) r_out <= w_res;
        if (w_fin) r_hold <= w_res;
    end

    assign o_in_stall     = (r_state != S_IDLE);
    assign o_out_valid    = r_out_valid;
    assign o_status       = r_out.status;
    assign o_result_index = r_out.index;
    assign o_result_data  = r_out.data;
    assign o_result_type  = r_out.tag;

    // a transfer in starts the work cycle
    a_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> (r_state == S_EXEC))
        else $error("accepted item did not start work");

    // a result is only parked while the output register is occupied
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_HOLD) |-> r_out_valid)
        else $error("result parked with output register empty");

    // a stalled result stays valid and unchanged
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(r_out)))
        else $error("stalled result changed or dropped");

endmodule
